// ===== hdl/dcbsr_pkg.sv =====
// Package: shared types and codes of the daisy-chain bus slave relay.
`timescale 1ns / 1ps
`default_nettype none

package dcbsr_pkg;

	// Widths of the bus fields
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;
	localparam int PHASE_W = 3;
	localparam int NIB_W   = 4;
	localparam int POS_W   = 5;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [NIB_W-1:0]   nib_t;
	typedef logic [POS_W-1:0]   pos_t;

	// Result kinds
	localparam kind_t KIND_RELAY      = 3'd0;
	localparam kind_t KIND_SET_OUTPUT = 3'd1;
	localparam kind_t KIND_SET_PWM    = 3'd2;
	localparam kind_t KIND_SERVO_CFG  = 3'd3;
	localparam kind_t KIND_SET_SERVO  = 3'd4;
	localparam kind_t KIND_SET_DATA   = 3'd5;

	// Packet parser phases; unused codes behave as PH_ID
	localparam phase_t PH_ID      = 3'd0;
	localparam phase_t PH_COUNT   = 3'd1;
	localparam phase_t PH_OPCODE  = 3'd2;
	localparam phase_t PH_OWN     = 3'd3;
	localparam phase_t PH_FOREIGN = 3'd4;
	localparam phase_t PH_CHECK   = 3'd5;

	// Command codes (high nibble of the opcode byte)
	localparam nib_t OP_SET_OUTPUT = 4'h2;
	localparam nib_t OP_SET_PWM    = 4'h3;
	localparam nib_t OP_SERVO_CFG  = 4'h7;
	localparam nib_t OP_SET_SERVO  = 4'h8;
	localparam nib_t OP_SET_DATA   = 4'h9;

endpackage : dcbsr_pkg

`default_nettype wire

// ===== hdl/dcbsr_in_if.sv =====
// Interface: input channel carrying one received bus byte per item.
`timescale 1ns / 1ps
`default_nettype none

interface dcbsr_in_if;
	logic                       valid;
	logic                       ready;
	logic [dcbsr_pkg::BYTE_W-1:0] rx_byte;
	logic [dcbsr_pkg::BYTE_W-1:0] input_bits;

	modport source (output valid, output rx_byte, output input_bits, input ready);
	modport sink   (input valid, input rx_byte, input input_bits, output ready);
endinterface : dcbsr_in_if

`default_nettype wire

// ===== hdl/dcbsr_out_if.sv =====
// Interface: output channel carrying one result item (relayed byte or action).
`timescale 1ns / 1ps
`default_nettype none

interface dcbsr_out_if;
	logic                         valid;
	logic                         ready;
	logic [dcbsr_pkg::KIND_W-1:0] kind;
	logic [dcbsr_pkg::BYTE_W-1:0] first_value;
	logic [dcbsr_pkg::BYTE_W-1:0] second_value;
	logic                         last;

	modport source (output valid, output kind, output first_value, output second_value,
		output last, input ready);
	modport sink   (input valid, input kind, input first_value, input second_value,
		input last, output ready);
endinterface : dcbsr_out_if

`default_nettype wire

// ===== hdl/dcbsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dcbsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule : dcbsr_ram

`default_nettype wire

// ===== hdl/daisy_chain_bus_slave_relay.sv =====
// Top level: slave relay of a daisy-chained byte bus with action dispatch.
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+-------------
//   rx      | in  | rx_byte[7:0], input_bits[7:0]             | valid/ready
//   tx      | out | kind[2:0], first_value, second_value, last | valid/ready
//
// A byte is accepted only while the sequencer is idle; its relayed byte is held
// in relay_q and leaves through the ST_RELAY state and the output register.
// An action result first takes two payload reads through the RAM port;
// set-data reads and emits each payload byte in turn, up to 15 of them.
// rx.ready is low while the sequencer works on the current byte; a stall on
// tx holds the sequencer. Reset clears the parser; payload RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module daisy_chain_bus_slave_relay #(
	parameter int PAYLOAD_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	dcbsr_in_if.sink   rx,
	dcbsr_out_if.source tx
);
	import dcbsr_pkg::*;

	localparam int AW = $clog2(PAYLOAD_DEPTH);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ADDR  = 2'd1;
	localparam logic [1:0] ST_DATA  = 2'd2;
	localparam logic [1:0] ST_RELAY = 2'd3;

	logic [1:0]    st_q, st_d;
	phase_t        phase_q, phase_d;
	byte_t         own_id_q, own_id_d;
	byte_t         msg_total_q, msg_total_d;
	byte_t         msg_num_q, msg_num_d;
	pos_t          byte_pos_q, byte_pos_d;
	nib_t          msg_len_q, msg_len_d;
	nib_t          own_len_q, own_len_d;
	nib_t          opcode_q, opcode_d;
	byte_t         relay_q;
	byte_t         p0_q;
	kind_t         act_kind_q;
	logic [AW-1:0] idx_q;

	logic          accept;
	byte_t         relay_d;
	byte_t         ored;
	pos_t          pos_inc;
	logic          wr_en;
	byte_t         wr_data;
	logic          dispatch;
	kind_t         act_kind_d;
	logic          act_start;
	byte_t         rd_data;
	logic          last_idx;

	logic          out_valid_q;
	kind_t         out_kind_q;
	byte_t         out_first_q;
	byte_t         out_second_q;
	logic          out_last_q;
	logic          out_free;
	logic          emit;
	kind_t         emit_kind;
	byte_t         emit_first;
	byte_t         emit_second;
	logic          emit_last;

	assign accept   = rx.valid && rx.ready;
	assign rx.ready = (st_q == ST_IDLE);
	assign ored     = rx.rx_byte | rx.input_bits;
	assign pos_inc  = byte_pos_q + 1'b1;

	// packet parser: next state for the accepted byte
	always_comb begin
		phase_d     = phase_q;
		own_id_d    = own_id_q;
		msg_total_d = msg_total_q;
		msg_num_d   = msg_num_q;
		byte_pos_d  = byte_pos_q;
		msg_len_d   = msg_len_q;
		own_len_d   = own_len_q;
		opcode_d    = opcode_q;
		relay_d     = rx.rx_byte;
		wr_en       = 1'b0;
		wr_data     = rx.rx_byte;
		dispatch    = 1'b0;
		unique case (phase_q)
			PH_COUNT: begin
				msg_total_d = rx.rx_byte;
				phase_d     = (rx.rx_byte == '0) ? PH_ID : PH_OPCODE;
			end
			PH_OPCODE: begin
				byte_pos_d = '0;
				msg_len_d  = rx.rx_byte[NIB_W-1:0];
				if (msg_num_q != own_id_q) begin
					phase_d = (rx.rx_byte[NIB_W-1:0] == '0) ? PH_CHECK : PH_FOREIGN;
				end else begin
					opcode_d  = rx.rx_byte[BYTE_W-1:NIB_W];
					own_len_d = rx.rx_byte[NIB_W-1:0];
					phase_d   = (rx.rx_byte[NIB_W-1:0] == '0) ? PH_CHECK : PH_OWN;
				end
			end
			PH_OWN: begin
				relay_d    = ored;
				wr_data    = ored;
				wr_en      = (32'(byte_pos_q) < PAYLOAD_DEPTH);
				byte_pos_d = pos_inc;
				if (pos_inc >= {1'b0, msg_len_q}) begin
					phase_d = PH_CHECK;
				end
			end
			PH_FOREIGN: begin
				byte_pos_d = pos_inc;
				if (pos_inc >= {1'b0, msg_len_q}) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				// checksum is stored unchecked at the current position
				wr_en     = (32'(byte_pos_q) < PAYLOAD_DEPTH);
				msg_num_d = msg_num_q + 1'b1;
				if (msg_num_q == msg_total_q) begin
					dispatch = 1'b1;
					phase_d  = PH_ID;
				end else begin
					phase_d = PH_OPCODE;
				end
			end
			default: begin
				own_id_d  = rx.rx_byte;
				msg_num_d = 8'd1;
				phase_d   = PH_COUNT;
				relay_d   = rx.rx_byte + 1'b1;
			end
		endcase
	end

	// dispatch decode from the stored opcode
	always_comb begin
		act_kind_d = KIND_RELAY;
		act_start  = 1'b0;
		unique case (opcode_q)
			OP_SET_OUTPUT: begin act_kind_d = KIND_SET_OUTPUT; act_start = dispatch; end
			OP_SET_PWM:    begin act_kind_d = KIND_SET_PWM;    act_start = dispatch; end
			OP_SERVO_CFG:  begin act_kind_d = KIND_SERVO_CFG;  act_start = dispatch; end
			OP_SET_SERVO:  begin act_kind_d = KIND_SET_SERVO;  act_start = dispatch; end
			OP_SET_DATA: begin
				act_kind_d = KIND_SET_DATA;
				act_start  = dispatch && (own_len_q != '0);
			end
			default: begin
				act_kind_d = KIND_RELAY;
				act_start  = 1'b0;
			end
		endcase
	end

	// payload store
	dcbsr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PAYLOAD_DEPTH)
	) u_payload (
		.clk     (clk),
		.wr_en   (accept && wr_en),
		.wr_addr (byte_pos_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign out_free = !out_valid_q || tx.ready;
	assign last_idx = (({1'b0, idx_q} + 1'b1) == (AW+1)'(own_len_q));

	// result selection and sequencer next state
	always_comb begin
		st_d        = st_q;
		emit        = 1'b0;
		emit_kind   = KIND_RELAY;
		emit_first  = relay_q;
		emit_second = '0;
		emit_last   = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					st_d = act_start ? ST_ADDR : ST_RELAY;
				end
			end
			ST_ADDR: begin
				st_d = ST_DATA;
			end
			ST_DATA: begin
				if (act_kind_q == KIND_SET_DATA) begin
					emit_kind  = KIND_SET_DATA;
					emit_first = rd_data;
					if (out_free) begin
						emit = 1'b1;
						st_d = last_idx ? ST_RELAY : ST_ADDR;
					end
				end else if (idx_q == '0) begin
					st_d = ST_ADDR;
				end else begin
					emit_kind   = act_kind_q;
					emit_first  = p0_q;
					emit_second = rd_data;
					if (out_free) begin
						emit = 1'b1;
						st_d = ST_RELAY;
					end
				end
			end
			default: begin
				emit_last = 1'b1;
				if (out_free) begin
					emit = 1'b1;
					st_d = ST_IDLE;
				end
			end
		endcase
	end

	// parser and sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			phase_q     <= PH_ID;
			own_id_q    <= '0;
			msg_total_q <= '0;
			msg_num_q   <= '0;
			byte_pos_q  <= '0;
			msg_len_q   <= '0;
			own_len_q   <= '0;
			opcode_q    <= '0;
			idx_q       <= '0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				phase_q     <= phase_d;
				own_id_q    <= own_id_d;
				msg_total_q <= msg_total_d;
				msg_num_q   <= msg_num_d;
				byte_pos_q  <= byte_pos_d;
				msg_len_q   <= msg_len_d;
				own_len_q   <= own_len_d;
				opcode_q    <= opcode_d;
				idx_q       <= '0;
			end else if (st_q == ST_DATA && (emit || (act_kind_q != KIND_SET_DATA
					&& idx_q == '0))) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// per-item working values
	always_ff @(posedge clk) begin
		if (accept) begin
			relay_q    <= relay_d;
			act_kind_q <= act_kind_d;
		end
		if (st_q == ST_DATA && idx_q == '0) begin
			p0_q <= rd_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q   <= emit_kind;
			out_first_q  <= emit_first;
			out_second_q <= emit_second;
			out_last_q   <= emit_last;
		end
	end

	assign tx.valid        = out_valid_q;
	assign tx.kind         = out_kind_q;
	assign tx.first_value  = out_first_q;
	assign tx.second_value = out_second_q;
	assign tx.last         = out_last_q;

endmodule : daisy_chain_bus_slave_relay

`default_nettype wire

// ===== test/daisy_chain_bus_slave_relay_test.sv =====
// Testbench: daisy_chain_bus_slave_relay checked against a packet parser predictor.
`timescale 1ns / 1ps
`default_nettype none

module daisy_chain_bus_slave_relay_test;
	import dcbsr_pkg::*;

	localparam int          RANDOM_BYTES = 210;
	localparam int          DRAIN_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          STORE_DEPTH  = 17;

	localparam nib_t ACTION_OPS [5] = '{OP_SET_OUTPUT, OP_SET_PWM, OP_SERVO_CFG,
		OP_SET_SERVO, OP_SET_DATA};

	typedef struct packed {
		kind_t kind;
		byte_t first;
		byte_t second;
		logic  last;
	} bus_result_t;

	logic clk;
	logic arst_n;

	dcbsr_in_if  rx ();
	dcbsr_out_if tx ();

	daisy_chain_bus_slave_relay u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.tx     (tx)
	);

	// Parser state mirrored from the bus protocol
	phase_t parse_phase = PH_ID;
	byte_t  slave_id    = '0;
	byte_t  msg_total   = '0;
	byte_t  msg_num     = '0;
	pos_t   byte_pos    = '0;
	nib_t   msg_len     = '0;
	nib_t   own_len     = '0;
	nib_t   own_cmd     = '0;
	byte_t  payload [STORE_DEPTH];

	bus_result_t results_due [$];

	int unsigned cycle_count   = 0;
	int unsigned bytes_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatches    = 0;
	int unsigned actions_due   = 0;
	int unsigned data_runs_due = 0;
	int unsigned own_op_turn   = 0;
	bit          no_idle       = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				results_due.size());
			$display("daisy_chain_bus_slave_relay_test: FAIL");
			$finish;
		end
	end

	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic byte_t draw_bits();
		return ($urandom_range(0, 1) == 0) ? 8'h00 : byte_t'($urandom);
	endfunction

	function automatic void due(input kind_t kind, input byte_t first, input byte_t second,
		input logic last);
		bus_result_t r;
		r.kind   = kind;
		r.first  = first;
		r.second = second;
		r.last   = last;
		results_due.push_back(r);
	endfunction

	// Advance the parser by one bus byte and queue the results it causes
	function automatic void parse_bus_byte(input byte_t rx_b, input byte_t bits);
		byte_t relay;
		relay = rx_b;
		case (parse_phase)
			PH_COUNT: begin
				msg_total   = rx_b;
				parse_phase = (rx_b == 8'h00) ? PH_ID : PH_OPCODE;
			end
			PH_OPCODE: begin
				byte_pos = '0;
				msg_len  = rx_b[3:0];
				if (msg_num != slave_id) begin
					parse_phase = (msg_len == 0) ? PH_CHECK : PH_FOREIGN;
				end else begin
					own_cmd     = rx_b[7:4];
					own_len     = msg_len;
					parse_phase = (msg_len == 0) ? PH_CHECK : PH_OWN;
				end
			end
			PH_OWN: begin
				relay = rx_b | bits;
				if (byte_pos < STORE_DEPTH)
					payload[byte_pos] = relay;
				byte_pos = byte_pos + 1'b1;
				if (byte_pos >= msg_len)
					parse_phase = PH_CHECK;
			end
			PH_FOREIGN: begin
				byte_pos = byte_pos + 1'b1;
				if (byte_pos >= msg_len)
					parse_phase = PH_CHECK;
			end
			PH_CHECK: begin
				// checksum is stored but never verified
				if (byte_pos < STORE_DEPTH)
					payload[byte_pos] = rx_b;
				if (msg_num == msg_total) begin
					// dispatch whatever own message was stored last
					case (own_cmd)
						OP_SET_OUTPUT: due(KIND_SET_OUTPUT, payload[0], payload[1], 1'b0);
						OP_SET_PWM:    due(KIND_SET_PWM, payload[0], payload[1], 1'b0);
						OP_SERVO_CFG:  due(KIND_SERVO_CFG, payload[0], payload[1], 1'b0);
						OP_SET_SERVO:  due(KIND_SET_SERVO, payload[0], payload[1], 1'b0);
						OP_SET_DATA: begin
							for (int i = 0; i < own_len; i++)
								due(KIND_SET_DATA, payload[i], 8'h00, 1'b0);
							data_runs_due++;
						end
						default: ;
					endcase
					if (own_cmd inside {OP_SET_OUTPUT, OP_SET_PWM, OP_SERVO_CFG, OP_SET_SERVO})
						actions_due++;
					parse_phase = PH_ID;
				end else begin
					parse_phase = PH_OPCODE;
				end
				msg_num = msg_num + 1'b1;
			end
			default: begin
				slave_id    = rx_b;
				msg_num     = 8'd1;
				parse_phase = PH_COUNT;
				relay       = rx_b + 1'b1;
			end
		endcase
		due(KIND_RELAY, relay, 8'h00, 1'b1);
	endfunction

	// Send one bus byte; valid stays high when the next item follows at once
	task automatic send_byte(input byte_t value, input byte_t bits);
		int unsigned gap;
		if ($urandom_range(0, 19) == 0)
			no_idle = !no_idle;
		gap = draw_gap();
		if (gap != 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid      <= 1'b1;
		rx.rx_byte    <= value;
		rx.input_bits <= bits;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		parse_bus_byte(value, bits);
		bytes_sent++;
	endtask

	// Result side back-pressure
	initial begin
		int unsigned gap;
		tx.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap != 0) begin
				tx.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx.ready <= 1'b1;
			@(posedge clk);
			while (!tx.valid) @(posedge clk);
		end
	end

	// Compare each accepted result with the oldest one due
	always @(posedge clk) begin : check_results
		bus_result_t want;
		if (arst_n && tx.valid && tx.ready) begin
			results_seen++;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, got kind %0d first %02h second %02h last %0b",
					$time, tx.kind, tx.first_value, tx.second_value, tx.last);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (tx.kind !== want.kind) begin
					$display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, tx.kind);
					mismatches++;
				end
				if (tx.first_value !== want.first) begin
					$display("%0t: first_value mismatch: expected %02h, got %02h", $time,
						want.first, tx.first_value);
					mismatches++;
				end
				if (tx.second_value !== want.second) begin
					$display("%0t: second_value mismatch: expected %02h, got %02h", $time,
						want.second, tx.second_value);
					mismatches++;
				end
				if (tx.last !== want.last) begin
					$display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, tx.last);
					mismatches++;
				end
			end
		end
	end

	// Own set-data message of full length; fills every payload entry an action can read
	task automatic test_set_data_fill();
		send_byte(8'd1, 8'h00);
		send_byte(8'd1, draw_bits());
		send_byte({OP_SET_DATA, 4'hF}, 8'h00);
		send_byte(8'h00, 8'h00);
		send_byte(8'h00, 8'hFF);
		send_byte(8'hFF, 8'h00);
		for (int i = 3; i < 15; i++)
			send_byte(byte_t'($urandom), draw_bits());
		send_byte(8'h5A, 8'hFF);
	endtask

	// ID that wraps when incremented, then an empty packet
	task automatic test_id_wrap_empty_packet();
		send_byte(8'hFF, 8'h00);
		send_byte(8'h00, 8'hFF);
	endtask

	// Foreign zero-length message, then a short own action
	task automatic test_short_own_action();
		send_byte(8'd2, 8'h00);
		send_byte(8'd2, 8'h00);
		send_byte({OP_SET_PWM, 4'h0}, 8'h00);
		send_byte(8'hA5, 8'h00);
		send_byte({OP_SET_SERVO, 4'h1}, 8'h00);
		send_byte(8'h12, 8'h40);
		send_byte(8'h00, 8'h00);
	endtask

	// Mostly well-formed packets with random content, plus noise and cut-off packets
	task automatic test_random_packets();
		int unsigned start, roll, n_msg, len, cut;
		byte_t       id;
		nib_t        cmd;
		byte_t       pkt [$];
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			pkt.delete();
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				repeat ($urandom_range(1, 6)) pkt.push_back(byte_t'($urandom));
			end else begin
				n_msg = (roll == 1) ? 0 : $urandom_range(1, 5);
				if (roll == 2 || n_msg == 0)
					id = byte_t'($urandom);
				else
					id = byte_t'($urandom_range(1, n_msg));
				pkt.push_back(id);
				pkt.push_back(byte_t'(n_msg));
				for (int m = 1; m <= n_msg; m++) begin
					if (m == id) begin
						cmd = (own_op_turn % 6 < 5) ? ACTION_OPS[own_op_turn % 6]
							: nib_t'($urandom_range(0, 15));
						own_op_turn++;
					end else begin
						cmd = nib_t'($urandom_range(0, 15));
					end
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
					pkt.push_back({cmd, nib_t'(len)});
					repeat (len) pkt.push_back(byte_t'($urandom));
					pkt.push_back(byte_t'($urandom));
				end
				// cut the packet short now and then
				if (roll == 3) begin
					cut = $urandom_range(1, pkt.size());
					while (pkt.size() > cut) void'(pkt.pop_back());
				end
			end
			foreach (pkt[i])
				send_byte(pkt[i], draw_bits());
		end
	endtask

	// Stimulus and end of run
	initial begin
		rx.valid      <= 1'b0;
		rx.rx_byte    <= '0;
		rx.input_bits <= '0;
		arst_n        <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_set_data_fill();
		test_id_wrap_empty_packet();
		test_short_own_action();
		test_random_packets();
		rx.valid <= 1'b0;

		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bus bytes, checked %0d results", bytes_sent, results_seen);
		$display("dispatched %0d actions and %0d set-data runs, %0d mismatches",
			actions_due, data_runs_due, mismatches);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("daisy_chain_bus_slave_relay_test: PASS");
		end else begin
			$display("daisy_chain_bus_slave_relay_test: FAIL");
		end
		$finish;
	end

endmodule : daisy_chain_bus_slave_relay_test

`default_nettype wire
